// ===== src/pot_conditioner_with_autopilot_latch_assert.svh =====
// assertion macros for the pot conditioner top level
`ifndef POT_CONDITIONER_WITH_AUTOPILOT_LATCH_ASSERT_SVH
`define POT_CONDITIONER_WITH_AUTOPILOT_LATCH_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define PC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define PC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/potcond_pkg.sv =====
// shared types and constants for the pot conditioner
package potcond_pkg;

    localparam int ADC_FULL_SCALE = 4095;

    localparam int RAW_W     = 12;
    localparam int GAIN_W    = 9;
    localparam int MAP_W     = 8;
    localparam int LEN_W     = 7;
    localparam int GAIN_FRAC = 8;
    localparam int GAIN_ONE  = 1 << GAIN_FRAC;
    localparam int MAP_MAX   = 100;
    localparam int MAP_MIN   = -100;

    localparam int SPAN_W    = RAW_W + 1;
    localparam int PROD_W    = 22;
    localparam int STEP_W    = PROD_W - GAIN_FRAC;
    localparam int NUM_W     = 20;
    localparam int DIV_N     = NUM_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_N);

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [RAW_W-1:0]  DEAD_BAND_RESET = 12'd10;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 9'd64;

    typedef enum logic [1:0] {
        REQ_UPDATE    = 2'd0,
        REQ_ENGAGE    = 2'd1,
        REQ_DISENGAGE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CH_DIR  = 2'd0,
        CH_TRIM = 2'd1,
        CH_LEN  = 2'd2
    } chan_t;

    typedef enum logic [2:0] {
        REG_DIR_LO  = 3'd0,
        REG_DIR_HI  = 3'd1,
        REG_TRIM_LO = 3'd2,
        REG_TRIM_HI = 3'd3,
        REG_LEN_LO  = 3'd4,
        REG_LEN_HI  = 3'd5,
        REG_DB      = 3'd6,
        REG_GAIN    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [RAW_W-1:0] dir_raw;
        logic [RAW_W-1:0] trim_raw;
        logic [RAW_W-1:0] len_raw;
    } in_word_t;

    typedef struct packed {
        logic signed [MAP_W-1:0] dir_out;
        logic signed [MAP_W-1:0] trim_out;
        logic [LEN_W-1:0]        len_out;
        logic                    dir_moved;
        logic                    trim_moved;
        logic                    len_moved;
        logic                    pilot_on;
        logic                    pilot_dropped;
        logic [RAW_W-1:0]        len_last_raw;
    } out_word_t;

    typedef struct packed {
        logic [RAW_W-1:0]  dir_low_cal;
        logic [RAW_W-1:0]  dir_high_cal;
        logic [RAW_W-1:0]  trim_low_cal;
        logic [RAW_W-1:0]  trim_high_cal;
        logic [RAW_W-1:0]  len_low_cal;
        logic [RAW_W-1:0]  len_high_cal;
        logic [RAW_W-1:0]  dead_band;
        logic [GAIN_W-1:0] smooth_gain_q8;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dir_low_cal:    '0,
        dir_high_cal:   RAW_W'(ADC_FULL_SCALE),
        trim_low_cal:   '0,
        trim_high_cal:  RAW_W'(ADC_FULL_SCALE),
        len_low_cal:    '0,
        len_high_cal:   RAW_W'(ADC_FULL_SCALE),
        dead_band:      DEAD_BAND_RESET,
        smooth_gain_q8: GAIN_RESET
    };

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  chk;
        logic  mul;
        logic  add;
        logic  map;
        logic  div_start;
        logic  fin;
        logic  pil;
        logic  out_load;
        chan_t chan;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_update;
        logic moved;
        logic div_done;
    } status_t;

endpackage

// ===== src/potcond_div.sv =====
// restoring divider, one quotient bit per cycle
module potcond_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [potcond_pkg::DIV_N-1:0]  dividend,
    input  logic [potcond_pkg::RAW_W-1:0]  divisor,
    output logic [potcond_pkg::DIV_N-1:0]  quotient,
    output logic                           done
);
    import potcond_pkg::*;

    logic [DIV_N-1:0]     acc_reg, acc_next;
    logic [RAW_W-1:0]     rem_reg, rem_next;
    logic [RAW_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RAW_W:0]       shifted;
    logic [RAW_W:0]       trial;
    logic                 qbit;

    // one shift and trial subtract per cycle
    always_comb
    begin
        shifted   = {rem_reg, acc_reg[DIV_N-1]};
        trial     = shifted - {1'b0, dvs_reg};
        qbit      = ~trial[RAW_W];
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? trial[RAW_W-1:0] : shifted[RAW_W-1:0];
            acc_next = {acc_reg[DIV_N-2:0], qbit};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = acc_reg;
    assign done     = done_reg;

endmodule

// ===== src/potcond_dp.sv =====
// datapath: channel state, smoothing, range mapping and autopilot latch
module potcond_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  potcond_pkg::cfg_t      cfg,
    input  potcond_pkg::in_word_t  in_data,
    input  potcond_pkg::cmd_t      cmd,
    output potcond_pkg::status_t   status,
    output potcond_pkg::out_word_t out_data
);
    import potcond_pkg::*;

    function automatic logic [RAW_W-1:0] dist_of(input logic signed [SPAN_W-1:0] v);
        logic signed [SPAN_W-1:0] n;
        n = -v;
        dist_of = v[SPAN_W-1] ? n[RAW_W-1:0] : v[RAW_W-1:0];
    endfunction

    // per-channel state
    logic [RAW_W-1:0]        last_raw_reg [3];
    logic [RAW_W-1:0]        last_raw_next [3];
    logic [RAW_W-1:0]        smooth_reg [3];
    logic [RAW_W-1:0]        smooth_next [3];
    logic signed [MAP_W-1:0] mapped_reg [3];
    logic signed [MAP_W-1:0] mapped_next [3];
    logic signed [MAP_W-1:0] saved_reg [3];
    logic signed [MAP_W-1:0] saved_next [3];
    logic [2:0]              moved_reg, moved_next;
    logic                    latch_reg, latch_next;
    logic                    dropped_reg, dropped_next;

    // working registers
    in_word_t                in_reg, in_next;
    logic [RAW_W-1:0]        x_reg, x_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic signed [SPAN_W-1:0] span_reg, span_next;
    logic                    cneg_reg, cneg_next;
    out_word_t               out_reg, out_next;

    // channel operands
    logic [1:0]              k;
    logic [RAW_W-1:0]        raw, lo, hi;
    logic                    centred;
    logic [RAW_W:0]          ctr_sum;
    logic [RAW_W-1:0]        ctr;
    logic signed [SPAN_W-1:0] raw_diff, ctr_diff;
    logic                    moved_now;
    logic                    snap;

    // smoothing and mapping
    logic [GAIN_W-1:0]       gain_eff;
    logic signed [SPAN_W-1:0] x_diff;
    logic signed [PROD_W:0]  prod_full;
    logic signed [PROD_W-1:0] prod_biased;
    logic signed [STEP_W-1:0] step;
    logic signed [STEP_W-1:0] smooth_sum;
    logic                    lower;
    logic [RAW_W-1:0]        map_a, map_b;
    logic signed [SPAN_W-1:0] s_off;
    logic signed [NUM_W-1:0] num_neg;
    logic [DIV_N-1:0]        dvd;
    logic [RAW_W-1:0]        dvs;
    logic [DIV_N-1:0]        quot;
    logic                    div_done;
    logic signed [NUM_W-1:0] q_pos, q_val;
    logic signed [NUM_W:0]   c_add, lo_bound, hi_bound, m_sum;
    logic signed [MAP_W-1:0] m_sat;

    // autopilot check
    logic signed [MAP_W:0]   pdiff [3];
    logic signed [MAP_W:0]   pneg [3];
    logic [MAP_W:0]          pdist [3];
    logic [2:0]              over;
    logic [RAW_W-2:0]        thr;

    assign k = cmd.chan;

    // select the sample and calibration of the current channel
    always_comb
    begin
        case (cmd.chan)
            CH_DIR:
            begin
                raw = in_reg.dir_raw;
                lo  = cfg.dir_low_cal;
                hi  = cfg.dir_high_cal;
            end
            CH_TRIM:
            begin
                raw = in_reg.trim_raw;
                lo  = cfg.trim_low_cal;
                hi  = cfg.trim_high_cal;
            end
            CH_LEN:
            begin
                raw = in_reg.len_raw;
                lo  = cfg.len_low_cal;
                hi  = cfg.len_high_cal;
            end
            default:
            begin
                raw = '0;
                lo  = '0;
                hi  = '0;
            end
        endcase
    end

    // deadzone check and centre snap
    always_comb
    begin
        centred   = (cmd.chan != CH_LEN);
        ctr_sum   = {1'b0, lo} + {1'b0, hi};
        ctr       = ctr_sum[RAW_W:1];
        raw_diff  = $signed({1'b0, raw}) - $signed({1'b0, last_raw_reg[k]});
        moved_now = dist_of(raw_diff) > cfg.dead_band;
        ctr_diff  = $signed({1'b0, raw}) - $signed({1'b0, ctr});
        snap      = centred && (dist_of(ctr_diff) < cfg.dead_band);
        x_next    = snap ? ctr : raw;
    end

    // exponential smoothing, product then truncating shift
    always_comb
    begin
        gain_eff    = (cfg.smooth_gain_q8 > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE)
                                                               : cfg.smooth_gain_q8;
        x_diff      = $signed({1'b0, x_reg}) - $signed({1'b0, smooth_reg[k]});
        prod_full   = $signed({1'b0, gain_eff}) * x_diff;
        prod_next   = prod_full[PROD_W-1:0];
        prod_biased = prod_reg[PROD_W-1] ? prod_reg + PROD_W'(GAIN_ONE - 1) : prod_reg;
        step        = STEP_W'(prod_biased >>> GAIN_FRAC);
        smooth_sum  = $signed({2'b00, smooth_reg[k]}) + step;
    end

    // piecewise map operands: numerator scaled by the output span, divisor span
    always_comb
    begin
        lower = smooth_reg[k] < ctr;
        if (centred && lower)
        begin
            map_a = lo;
            map_b = ctr;
        end
        else if (centred)
        begin
            map_a = ctr;
            map_b = hi;
        end
        else
        begin
            map_a = lo;
            map_b = hi;
        end
        s_off     = $signed({1'b0, smooth_reg[k]}) - $signed({1'b0, map_a});
        num_next  = NUM_W'(s_off) * NUM_W'(MAP_MAX);
        span_next = $signed({1'b0, map_b}) - $signed({1'b0, map_a});
        cneg_next = centred && lower;
    end

    // divider magnitudes
    always_comb
    begin
        num_neg = -num_reg;
        dvd     = num_reg[NUM_W-1] ? num_neg[DIV_N-1:0] : num_reg[DIV_N-1:0];
        dvs     = dist_of(span_reg);
    end

    potcond_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .quotient (quot),
        .done     (div_done)
    );

    // signed quotient, offset and saturation
    always_comb
    begin
        q_pos = $signed({1'b0, quot});
        if (span_reg == '0)
            q_val = '0;
        else if (num_reg[NUM_W-1] ^ span_reg[SPAN_W-1])
            q_val = -q_pos;
        else
            q_val = q_pos;
        c_add    = cneg_reg ? (NUM_W + 1)'(MAP_MIN) : (NUM_W + 1)'(0);
        lo_bound = centred ? (NUM_W + 1)'(MAP_MIN) : (NUM_W + 1)'(0);
        hi_bound = (NUM_W + 1)'(MAP_MAX);
        m_sum    = (NUM_W + 1)'(q_val) + c_add;
        if (m_sum > hi_bound)
            m_sat = hi_bound[MAP_W-1:0];
        else if (m_sum < lo_bound)
            m_sat = lo_bound[MAP_W-1:0];
        else
            m_sat = m_sum[MAP_W-1:0];
    end

    // drift of each mapped value from its saved value
    always_comb
    begin
        thr = cfg.dead_band[RAW_W-1:1];
        for (int i = 0; i < 3; i++)
        begin
            pdiff[i] = $signed({mapped_reg[i][MAP_W-1], mapped_reg[i]})
                     - $signed({saved_reg[i][MAP_W-1], saved_reg[i]});
            pneg[i]  = -pdiff[i];
            pdist[i] = pdiff[i][MAP_W] ? pneg[i] : pdiff[i];
            over[i]  = pdist[i] > {1'b0, thr};
        end
    end

    // next state of the channel registers and the latch
    always_comb
    begin
        in_next      = in_reg;
        moved_next   = moved_reg;
        latch_next   = latch_reg;
        dropped_next = dropped_reg;
        for (int i = 0; i < 3; i++)
        begin
            last_raw_next[i] = last_raw_reg[i];
            smooth_next[i]   = smooth_reg[i];
            mapped_next[i]   = mapped_reg[i];
            saved_next[i]    = saved_reg[i];
        end
        if (cmd.load)
        begin
            in_next      = in_data;
            moved_next   = '0;
            dropped_next = 1'b0;
        end
        if (cmd.chk)
        begin
            last_raw_next[k] = raw;
            moved_next[k]    = moved_now;
        end
        if (cmd.add)
            smooth_next[k] = smooth_sum[RAW_W-1:0];
        if (cmd.fin)
            mapped_next[k] = m_sat;
        if (cmd.pil)
        begin
            case (in_reg.req_type)
                REQ_UPDATE:
                begin
                    if (latch_reg && (over != '0))
                    begin
                        dropped_next = 1'b1;
                        latch_next   = 1'b0;
                    end
                end
                REQ_ENGAGE:
                begin
                    if (!latch_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                            saved_next[i] = mapped_reg[i];
                    end
                    latch_next = 1'b1;
                end
                REQ_DISENGAGE:
                begin
                    latch_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result word
    always_comb
    begin
        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_next.dir_out       = mapped_reg[CH_DIR];
            out_next.trim_out      = mapped_reg[CH_TRIM];
            out_next.len_out       = mapped_reg[CH_LEN][LEN_W-1:0];
            out_next.dir_moved     = moved_reg[CH_DIR];
            out_next.trim_moved    = moved_reg[CH_TRIM];
            out_next.len_moved     = moved_reg[CH_LEN];
            out_next.pilot_on      = latch_reg;
            out_next.pilot_dropped = dropped_reg;
            out_next.len_last_raw  = last_raw_reg[CH_LEN];
        end
    end

    // channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                last_raw_reg[i] <= '0;
                smooth_reg[i]   <= '0;
                mapped_reg[i]   <= '0;
                saved_reg[i]    <= '0;
            end
            moved_reg   <= '0;
            latch_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                last_raw_reg[i] <= last_raw_next[i];
                smooth_reg[i]   <= smooth_next[i];
                mapped_reg[i]   <= mapped_next[i];
                saved_reg[i]    <= saved_next[i];
            end
            moved_reg   <= moved_next;
            latch_reg   <= latch_next;
            dropped_reg <= dropped_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        out_reg <= out_next;
        if (cmd.chk)
            x_reg <= x_next;
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.map)
        begin
            num_reg  <= num_next;
            span_reg <= span_next;
            cneg_reg <= cneg_next;
        end
    end

    assign status.is_update = (in_reg.req_type == REQ_UPDATE);
    assign status.moved     = moved_now;
    assign status.div_done  = div_done;
    assign out_data         = out_reg;

endmodule

// ===== src/potcond_ctrl.sv =====
// controller: sequences the three channels through the shared datapath
module potcond_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  potcond_pkg::status_t status,
    output potcond_pkg::cmd_t    cmd
);
    import potcond_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DISP = 11'b000_0000_0010,
        S_CHK  = 11'b000_0000_0100,
        S_MUL  = 11'b000_0000_1000,
        S_ADD  = 11'b000_0001_0000,
        S_MAP  = 11'b000_0010_0000,
        S_DIV  = 11'b000_0100_0000,
        S_WAIT = 11'b000_1000_0000,
        S_FIN  = 11'b001_0000_0000,
        S_PIL  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    chan_t  chan_reg, chan_next;
    logic   out_valid_reg, out_valid_next;
    state_t after_chan;
    chan_t  chan_inc;

    // where to go once the current channel is finished
    always_comb
    begin
        chan_inc   = chan_t'(chan_reg + 2'd1);
        after_chan = (chan_reg == CH_LEN) ? S_PIL : S_CHK;
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.chan       = chan_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                chan_next  = CH_DIR;
                state_next = status.is_update ? S_CHK : S_PIL;
            end
            S_CHK:
            begin
                cmd.chk = 1'b1;
                if (status.moved)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = after_chan;
                    if (chan_reg != CH_LEN)
                        chan_next = chan_inc;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_MAP;
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = after_chan;
                if (chan_reg != CH_LEN)
                    chan_next = chan_inc;
            end
            S_PIL:
            begin
                cmd.pil    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= CH_DIR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/pot_conditioner_with_autopilot_latch.sv =====
// top level: configuration registers, controller and datapath
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     in_data  (request and three samples)
//  out       output     out_valid / out_stall   out_data (mapped values and flags)
//  config    input      APB psel/penable/pwrite paddr, pwdata, prdata
//
// an engage, disengage or ignored request passes through the dispatch, latch and done states
// an update checks each channel in turn and, where its sample moved past the deadzone, runs
// multiply, add, map, divider start, divider wait and finish before the latch check
// control and channel state clear at reset; calibration resets to full scale, latch off
// a result waits in the output register while out_stall is high; the next word is
// accepted meanwhile and held at its end until the output register is free
module pot_conditioner_with_autopilot_latch (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [potcond_pkg::APB_AW-1:0]   paddr,
    input  logic [potcond_pkg::APB_DW-1:0]   pwdata,
    output logic [potcond_pkg::APB_DW-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  potcond_pkg::in_word_t            in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output potcond_pkg::out_word_t           out_data
);
    import potcond_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    cmd_t     cmd;
    status_t  status;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_DIR_LO:  cfg_next.dir_low_cal    = pwdata[RAW_W-1:0];
                REG_DIR_HI:  cfg_next.dir_high_cal   = pwdata[RAW_W-1:0];
                REG_TRIM_LO: cfg_next.trim_low_cal   = pwdata[RAW_W-1:0];
                REG_TRIM_HI: cfg_next.trim_high_cal  = pwdata[RAW_W-1:0];
                REG_LEN_LO:  cfg_next.len_low_cal    = pwdata[RAW_W-1:0];
                REG_LEN_HI:  cfg_next.len_high_cal   = pwdata[RAW_W-1:0];
                REG_DB:      cfg_next.dead_band      = pwdata[RAW_W-1:0];
                REG_GAIN:    cfg_next.smooth_gain_q8 = pwdata[GAIN_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (reg_idx)
            REG_DIR_LO:  prdata = APB_DW'(cfg_reg.dir_low_cal);
            REG_DIR_HI:  prdata = APB_DW'(cfg_reg.dir_high_cal);
            REG_TRIM_LO: prdata = APB_DW'(cfg_reg.trim_low_cal);
            REG_TRIM_HI: prdata = APB_DW'(cfg_reg.trim_high_cal);
            REG_LEN_LO:  prdata = APB_DW'(cfg_reg.len_low_cal);
            REG_LEN_HI:  prdata = APB_DW'(cfg_reg.len_high_cal);
            REG_DB:      prdata = APB_DW'(cfg_reg.dead_band);
            REG_GAIN:    prdata = APB_DW'(cfg_reg.smooth_gain_q8);
            default:     prdata = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    potcond_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    potcond_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

    `include "pot_conditioner_with_autopilot_latch_assert.svh"

    // mapped outputs stay inside their saturated ranges
    `PC_ASSERT_SAME(a_out_range, out_valid, ($signed(out_data.dir_out) <= 8'sd100) && ($signed(out_data.dir_out) >= -8'sd100) && ($signed(out_data.trim_out) <= 8'sd100) && ($signed(out_data.trim_out) >= -8'sd100) && (out_data.len_out <= 7'd100), "mapped output out of range")
    // a held result is never overwritten
    `PC_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(out_valid && out_stall), "output register overwritten while stalled")
    // a released latch is reported as off
    `PC_ASSERT_SAME(a_drop_clears, out_valid && out_data.pilot_dropped, !out_data.pilot_on, "latch dropped but still on")
    // one word at a time through the controller
    `PC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after accept")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the pot conditioner with autopilot latch
`timescale 1ns / 1ps

module testbench;
    import potcond_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_OFF     = 300;
    localparam int SETTLE       = 90;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // clock, reset and block ports
    logic clk;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_word_t out_data;

    // traffic shaping
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    int mismatch_count = 0;

    // conditioner state as the testbench tracks it
    cfg_t cur_cfg = CFG_RESET;
    int filt_val[3] = '{0, 0, 0};
    int pct_val[3] = '{0, 0, 0};
    int prev_raw[3] = '{0, 0, 0};
    bit latch_on = 1'b0;
    int latch_pct[3] = '{0, 0, 0};
    out_word_t awaited_words[$];

    pot_conditioner_with_autopilot_latch i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pot_conditioner_with_autopilot_latch: mismatch");
            $finish;
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // exponential smoothing, gain saturates at unity
    function automatic int smooth_toward(int x, int old);
        int g;
        g = cur_cfg.smooth_gain_q8;
        if (g > GAIN_ONE)
            g = GAIN_ONE;
        return old + (g * (x - old)) / GAIN_ONE;
    endfunction

    // linear map, division truncates toward zero, zero span gives c
    function automatic int scale_span(int s, int a, int b, int c, int d);
        int span;
        span = b - a;
        if (span == 0)
            return c;
        return ((s - a) * (d - c)) / span + c;
    endfunction

    // one channel: deadzone, centre snap, smoothing, mapping
    function automatic bit condition_channel(int k, int raw, int lo, int hi, bit centred);
        int db;
        int ctr;
        int x;
        int m;
        db = cur_cfg.dead_band;
        if (iabs(raw - prev_raw[k]) <= db)
        begin
            prev_raw[k] = raw;
            return 1'b0;
        end
        prev_raw[k] = raw;
        if (centred)
        begin
            ctr = (lo + hi) / 2;
            x = (iabs(raw - ctr) < db) ? ctr : raw;
            filt_val[k] = smooth_toward(x, filt_val[k]);
            if (filt_val[k] < ctr)
                m = scale_span(filt_val[k], lo, ctr, MAP_MIN, 0);
            else
                m = scale_span(filt_val[k], ctr, hi, 0, MAP_MAX);
            pct_val[k] = clamp(m, MAP_MIN, MAP_MAX);
        end
        else
        begin
            filt_val[k] = smooth_toward(raw, filt_val[k]);
            pct_val[k] = clamp(scale_span(filt_val[k], lo, hi, 0, MAP_MAX), 0, MAP_MAX);
        end
        return 1'b1;
    endfunction

    // advance the tracked state by one word and build the result it causes
    function automatic out_word_t conditioned_word(in_word_t w);
        out_word_t o;
        logic [2:0] moved;
        bit dropped;
        int thr;
        moved = '0;
        dropped = 1'b0;
        case (w.req_type)
            REQ_UPDATE:
            begin
                moved[0] = condition_channel(int'(CH_DIR), w.dir_raw,
                    cur_cfg.dir_low_cal, cur_cfg.dir_high_cal, 1'b1);
                moved[1] = condition_channel(int'(CH_TRIM), w.trim_raw,
                    cur_cfg.trim_low_cal, cur_cfg.trim_high_cal, 1'b1);
                moved[2] = condition_channel(int'(CH_LEN), w.len_raw,
                    cur_cfg.len_low_cal, cur_cfg.len_high_cal, 1'b0);
                if (latch_on)
                begin
                    thr = cur_cfg.dead_band / 2;
                    for (int k = 0; k < 3; k++)
                        if (iabs(pct_val[k] - latch_pct[k]) > thr)
                            dropped = 1'b1;
                    if (dropped)
                        latch_on = 1'b0;
                end
            end
            REQ_ENGAGE:
            begin
                // a second engage keeps the values saved by the first
                if (!latch_on)
                    latch_pct = pct_val;
                latch_on = 1'b1;
            end
            REQ_DISENGAGE:
                latch_on = 1'b0;
            default:
                ;
        endcase
        o.dir_out       = MAP_W'(pct_val[int'(CH_DIR)]);
        o.trim_out      = MAP_W'(pct_val[int'(CH_TRIM)]);
        o.len_out       = LEN_W'(pct_val[int'(CH_LEN)]);
        o.dir_moved     = moved[0];
        o.trim_moved    = moved[1];
        o.len_moved     = moved[2];
        o.pilot_on      = latch_on;
        o.pilot_dropped = dropped;
        o.len_last_raw  = RAW_W'(prev_raw[int'(CH_LEN)]);
        return o;
    endfunction

    task automatic check_field(string name, logic signed [12:0] exp_v,
                               logic signed [12:0] got_v);
        if (got_v !== exp_v)
        begin
            if (mismatch_count < 10)
                $display("%0t %s: expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_words.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t unexpected result word %p", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                exp_w = awaited_words.pop_front();
                check_field("dir_out", exp_w.dir_out, out_data.dir_out);
                check_field("trim_out", exp_w.trim_out, out_data.trim_out);
                check_field("len_out", exp_w.len_out, out_data.len_out);
                check_field("dir_moved", exp_w.dir_moved, out_data.dir_moved);
                check_field("trim_moved", exp_w.trim_moved, out_data.trim_moved);
                check_field("len_moved", exp_w.len_moved, out_data.len_moved);
                check_field("pilot_on", exp_w.pilot_on, out_data.pilot_on);
                check_field("pilot_dropped", exp_w.pilot_dropped, out_data.pilot_dropped);
                check_field("len_last_raw", exp_w.len_last_raw, out_data.len_last_raw);
            end
        end
    end

    // offer one word, hold it until accepted, then record its result
    task automatic send_word(in_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        awaited_words.push_back(conditioned_word(w));
        @(negedge clk);
    endtask

    function automatic in_word_t make_word(logic [1:0] req, int d, int t, int l);
        in_word_t w;
        w.req_type = req;
        w.dir_raw  = RAW_W'(d);
        w.trim_raw = RAW_W'(t);
        w.len_raw  = RAW_W'(l);
        return w;
    endfunction

    // sample near the last one, near the centre, at an end, or anywhere
    function automatic int pick_sample(int prev, int ctr);
        case ($urandom_range(3))
            0: return clamp(prev + $urandom_range(80) - 40, 0, ADC_FULL_SCALE);
            1: return clamp(ctr + $urandom_range(30) - 15, 0, ADC_FULL_SCALE);
            2: return $urandom_range(1) ? ADC_FULL_SCALE : 0;
            default: return $urandom_range(ADC_FULL_SCALE);
        endcase
    endfunction

    function automatic in_word_t random_word();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return make_word(REQ_ENGAGE, $urandom, $urandom, $urandom);
        if (r < 14)
            return make_word(REQ_DISENGAGE, $urandom, $urandom, $urandom);
        if (r < 17)
            return make_word(REQ_RESERVED, $urandom, $urandom, $urandom);
        return make_word(REQ_UPDATE,
            pick_sample(prev_raw[0], (cur_cfg.dir_low_cal + cur_cfg.dir_high_cal) / 2),
            pick_sample(prev_raw[1], (cur_cfg.trim_low_cal + cur_cfg.trim_high_cal) / 2),
            pick_sample(prev_raw[2], (cur_cfg.len_low_cal + cur_cfg.len_high_cal) / 2));
    endfunction

    task automatic run_traffic(int n);
        repeat (n) send_word(random_word());
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one APB transfer: setup, access, then idle
    task automatic apb_access(bit wr, reg_idx_t r, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'(4 * int'(r));
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] reg_value(cfg_t c, reg_idx_t r);
        case (r)
            REG_DIR_LO:  return c.dir_low_cal;
            REG_DIR_HI:  return c.dir_high_cal;
            REG_TRIM_LO: return c.trim_low_cal;
            REG_TRIM_HI: return c.trim_high_cal;
            REG_LEN_LO:  return c.len_low_cal;
            REG_LEN_HI:  return c.len_high_cal;
            REG_DB:      return c.dead_band;
            default:     return c.smooth_gain_q8;
        endcase
    endfunction

    // write every register, sometimes with junk above the field, then read back
    task automatic program_regs(cfg_t c);
        reg_idx_t r;
        logic [31:0] mask;
        logic [31:0] v;
        logic [31:0] rd;
        for (int i = 0; i < 8; i++)
        begin
            r = reg_idx_t'(i);
            mask = (r == REG_GAIN) ? 32'h1FF : 32'hFFF;
            v = reg_value(c, r);
            if ($urandom_range(1))
                v = v | ($urandom & ~mask);
            apb_access(1'b1, r, v, rd);
        end
        cur_cfg = c;
        for (int i = 0; i < 8; i++)
        begin
            r = reg_idx_t'(i);
            apb_access(1'b0, r, '0, rd);
            check_field(r.name(), reg_value(c, r), rd[12:0]);
        end
    endtask

    task automatic test_reset_values();
        reg_idx_t r;
        logic [31:0] rd;
        for (int i = 0; i < 8; i++)
        begin
            r = reg_idx_t'(i);
            apb_access(1'b0, r, '0, rd);
            check_field(r.name(), reg_value(CFG_RESET, r), rd[12:0]);
        end
    endtask

    // extremes, centre snap, latch engage/keep/drop/release, ignored request
    task automatic test_directed();
        send_word(make_word(REQ_UPDATE, 0, 0, 0));
        send_word(make_word(REQ_UPDATE, 4095, 4095, 4095));
        send_word(make_word(REQ_UPDATE, 4095, 0, 4095));
        send_word(make_word(REQ_UPDATE, 2050, 2040, 2000));
        send_word(make_word(REQ_UPDATE, 2047, 2047, 2047));
        send_word(make_word(REQ_ENGAGE, 0, 0, 0));
        send_word(make_word(REQ_ENGAGE, 4095, 4095, 4095));
        send_word(make_word(REQ_UPDATE, 2045, 2052, 2052));
        send_word(make_word(REQ_UPDATE, 2070, 2030, 2100));
        send_word(make_word(REQ_UPDATE, 0, 4095, 0));
        send_word(make_word(REQ_ENGAGE, 0, 0, 0));
        send_word(make_word(REQ_DISENGAGE, 0, 0, 0));
        send_word(make_word(REQ_DISENGAGE, 4095, 4095, 4095));
        send_word(make_word(REQ_RESERVED, 4095, 4095, 4095));
        send_word(make_word(REQ_RESERVED, 0, 0, 0));
        send_word(make_word(REQ_UPDATE, 1, 4094, 2048));
        send_word(make_word(REQ_UPDATE, 4095, 0, 4095));
        send_word(make_word(REQ_ENGAGE, 0, 0, 0));
        send_word(make_word(REQ_UPDATE, 4000, 100, 3000));
        send_word(make_word(REQ_DISENGAGE, 0, 0, 0));
        drain();
    endtask

    // calibration, deadzone and gain corners, each with random traffic
    task automatic test_config_sweep();
        cfg_t sets[5];
        sets[0] = '{12'd100, 12'd3900, 12'd500, 12'd3500, 12'd200, 12'd4000,
                    12'd0, 9'd256};
        sets[1] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095,
                    12'd4095, 9'd0};
        // zero spans
        sets[2] = '{12'd2048, 12'd2048, 12'd0, 12'd0, 12'd4095, 12'd4095,
                    12'd20, 9'd511};
        // inverted calibration
        sets[3] = '{12'd3000, 12'd1000, 12'd4095, 12'd0, 12'd4095, 12'd0,
                    12'd3, 9'd300};
        sets[4] = CFG_RESET;
        sets[4].smooth_gain_q8 = 9'd128;
        send_idle_pct = 12;
        stall_pct = 12;
        foreach (sets[i])
        begin
            program_regs(sets[i]);
            run_traffic(30);
            drain();
        end
    endtask

    task automatic test_idle_phases();
        int idle_mix[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{12, 12}};
        foreach (idle_mix[i])
        begin
            send_idle_pct = idle_mix[i][0];
            stall_pct = idle_mix[i][1];
            run_traffic(60);
        end
        drain();
    endtask

    // receiver holds off while words keep coming, so the input backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = HOLD_OFF;
        run_traffic(30);
        drain();
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_directed();
        test_config_sweep();
        test_idle_phases();
        test_backpressure();
        repeat (SETTLE) @(negedge clk);
        if (mismatch_count == 0 && awaited_words.size() == 0)
            $display("pot_conditioner_with_autopilot_latch: match");
        else
            $display("pot_conditioner_with_autopilot_latch: mismatch");
        $finish;
    end

endmodule
